// File: rtl/pdci_pkg.sv
// pdci_pkg: shared types and constants of the paced DMA chunk issuer.
// Holds opcodes, status codes, register indexes and the config struct.
// No dependencies.
package pdci_pkg;

  // Fixed field widths
  localparam int unsigned AddrW   = 48;
  localparam int unsigned BytesW  = 40;
  localparam int unsigned LenW    = 25;
  localparam int unsigned RateW   = 16;
  localparam int unsigned CountW  = 32;
  localparam int unsigned DepthW  = 4;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned PdataW  = 32;

  // Largest legal chunk (2^24 bytes)
  localparam logic [LenW-1:0] ChunkMax = 25'h100_0000;

  // Register reset values
  localparam logic [LenW-1:0]   ChunkSizeRst   = 25'h010_0000;
  localparam logic              PacingOffRst   = 1'b0;
  localparam logic [DepthW-1:0] WindowDepthRst = 4'd2;

  // Register indexes (word address paddr[3:2])
  typedef enum logic [1:0] {
    REG_CHUNK_SIZE   = 2'd0,
    REG_PACING_OFF   = 2'd1,
    REG_WINDOW_DEPTH = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_START        = 3'd0,
    OP_TICK         = 3'd1,
    OP_DONE         = 3'd2,
    OP_SET_RATE     = 3'd3,
    OP_CANCEL       = 3'd4,
    OP_CLEAR_CANCEL = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_ACK        = 3'd0,
    ST_ISSUED     = 3'd1,
    ST_WAITING    = 3'd2,
    ST_FINISHED   = 3'd3,
    ST_CANCELLED  = 3'd4,
    ST_SIZE_ERROR = 3'd5,
    ST_BUSY       = 3'd6
  } status_e;

  // Configuration seen by the core
  typedef struct packed {
    logic [LenW-1:0]   chunk_size;
    logic              pacing_off;
    logic [DepthW-1:0] window_depth;
  } cfg_t;

  // One input beat
  typedef struct packed {
    logic [2:0]        opcode;
    logic [BytesW-1:0] job_bytes;
    logic [AddrW-1:0]  source_base;
    logic [AddrW-1:0]  dest_base;
    logic [AddrW-1:0]  first_due;
    logic [RateW-1:0]  rate_value;
  } item_t;

  // One result beat
  typedef struct packed {
    status_e           status;
    logic [AddrW-1:0]  source_address;
    logic [AddrW-1:0]  dest_address;
    logic [LenW-1:0]   chunk_length;
    logic              last_chunk;
    logic [CountW-1:0] chunks_sent;
    logic [BytesW-1:0] bytes_sent;
    logic [AddrW-1:0]  gap_ticks;
    logic [AddrW-1:0]  deadline_now;
    logic [DepthW-1:0] in_flight;
    logic              was_cancelled;
  } result_t;

endpackage

// File: rtl/pdci_cfg.sv
// pdci_cfg: APB-style register file for chunk size, pacing mode and window.
// Depends on pdci_pkg.
module pdci_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdci_pkg::PaddrW-1:0]   paddr,
  input  logic [pdci_pkg::PdataW-1:0]   pwdata,
  output logic [pdci_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output pdci_pkg::cfg_t                cfg_o
);
  import pdci_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  // Register write decode; the unused word is dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_CHUNK_SIZE:   cfg_d.chunk_size   = pwdata[LenW-1:0];
        REG_PACING_OFF:   cfg_d.pacing_off   = pwdata[0];
        REG_WINDOW_DEPTH: cfg_d.window_depth = pwdata[DepthW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chunk_size   <= ChunkSizeRst;
      cfg_q.pacing_off   <= PacingOffRst;
      cfg_q.window_depth <= WindowDepthRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_CHUNK_SIZE:   prdata = {{(PdataW-LenW){1'b0}}, cfg_q.chunk_size};
      REG_PACING_OFF:   prdata = {{(PdataW-1){1'b0}}, cfg_q.pacing_off};
      REG_WINDOW_DEPTH: prdata = {{(PdataW-DepthW){1'b0}}, cfg_q.window_depth};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/pdci_core.sv
// pdci_core: job state and the single-pass step for one beat.
// Holds time, deadline, offsets and counters; depends on pdci_pkg.
module pdci_core #(
  parameter int unsigned MAX_WINDOW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  pdci_pkg::item_t   item_i,
  input  pdci_pkg::cfg_t    cfg_i,
  output pdci_pkg::result_t res_o
);
  import pdci_pkg::*;

  localparam logic [AddrW-1:0]  AddrMax  = {AddrW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  // Window clamp limited to what the 4-bit register can express
  localparam int unsigned       WinCap   = (MAX_WINDOW > 15) ? 15 : MAX_WINDOW;
  localparam logic [DepthW-1:0] WinMax   = DepthW'(WinCap);

  logic [AddrW-1:0]  time_q, time_d, due_q, due_d, src_q, src_d, dst_q, dst_d;
  logic [AddrW-1:0]  gap_cnt_q, gap_cnt_d;
  logic [BytesW-1:0] total_q, total_d, offset_q, offset_d;
  logic [DepthW-1:0] outst_q, outst_d;
  logic [CountW-1:0] chunks_q, chunks_d;
  logic [RateW-1:0]  rate_q, rate_d;
  logic              run_q, run_d, cflag_q, cflag_d, jcan_q, jcan_d;

  // Per-beat datapath
  logic [AddrW-1:0]  time_inc, base, due_issue, sa, da;
  logic [AddrW:0]    time_sum, due_sum;
  logic [BytesW-1:0] rem, offset_issue;
  logic [LenW-1:0]   cs, len;
  logic [DepthW-1:0] depth;
  logic [40:0]       prod;
  logic [33:0]       gap;
  logic              has_left, tick_cancel, tick_drain;
  logic [AddrW:0]    gcnt_sum;
  op_e               op;
  status_e           status;
  logic [AddrW-1:0]  res_sa, res_da;
  logic [LenW-1:0]   res_len;
  logic              res_last;

  assign op       = op_e'(item_i.opcode);
  assign has_left = offset_q < total_q;
  assign rem      = total_q - offset_q;

  // Saturating time advance
  assign time_sum = {1'b0, time_q} + {{AddrW{1'b0}}, 1'b1};
  assign time_inc = time_sum[AddrW] ? AddrMax : time_sum[AddrW-1:0];
  assign gcnt_sum = {1'b0, gap_cnt_q} + {{AddrW{1'b0}}, 1'b1};

  // Clamped chunk size and window
  always_comb begin
    if (cfg_i.chunk_size == '0) cs = {{(LenW-1){1'b0}}, 1'b1};
    else if (cfg_i.chunk_size > ChunkMax) cs = ChunkMax;
    else cs = cfg_i.chunk_size;
    if (cfg_i.window_depth == '0) depth = {{(DepthW-1){1'b0}}, 1'b1};
    else if (cfg_i.window_depth > WinMax) depth = WinMax;
    else depth = cfg_i.window_depth;
  end

  // Issue datapath: length, addresses, paced deadline
  assign len          = (rem < {{(BytesW-LenW){1'b0}}, cs}) ? rem[LenW-1:0] : cs;
  assign offset_issue = offset_q + {{(BytesW-LenW){1'b0}}, len};
  assign sa           = src_q + {{(AddrW-BytesW){1'b0}}, offset_q};
  assign da           = dst_q + {{(AddrW-BytesW){1'b0}}, offset_q};
  assign prod         = {16'd0, len} * {25'd0, rate_q};
  assign gap          = 34'((42'(prod) + 42'd128) >> 8);
  assign base         = (time_inc > due_q) ? time_inc : due_q;
  assign due_sum      = {1'b0, base} + {15'd0, gap};
  assign due_issue    = due_sum[AddrW] ? AddrMax : due_sum[AddrW-1:0];

  assign tick_cancel  = cflag_q && has_left;
  assign tick_drain   = jcan_q || tick_cancel || !has_left;

  // Next state and result for the beat in the input register
  always_comb begin
    time_d    = time_q;
    due_d     = due_q;
    src_d     = src_q;
    dst_d     = dst_q;
    gap_cnt_d = gap_cnt_q;
    total_d   = total_q;
    offset_d  = offset_q;
    outst_d   = outst_q;
    chunks_d  = chunks_q;
    rate_d    = rate_q;
    run_d     = run_q;
    cflag_d   = cflag_q;
    jcan_d    = jcan_q;
    status    = ST_ACK;
    res_sa    = '0;
    res_da    = '0;
    res_len   = '0;
    res_last  = 1'b0;
    unique case (op)
      OP_START: begin
        if (run_q) begin
          status = ST_BUSY;
        end else if (item_i.job_bytes == '0) begin
          status = ST_SIZE_ERROR;
        end else begin
          total_d   = item_i.job_bytes;
          offset_d  = '0;
          src_d     = item_i.source_base;
          dst_d     = item_i.dest_base;
          due_d     = (item_i.first_due != '0) ? item_i.first_due : time_q;
          outst_d   = '0;
          chunks_d  = '0;
          gap_cnt_d = '0;
          jcan_d    = 1'b0;
          run_d     = 1'b1;
        end
      end
      OP_TICK: begin
        time_d = time_inc;
        if (run_q) begin
          if (tick_cancel) jcan_d = 1'b1;
          if (tick_drain) begin
            if (outst_q == '0) begin
              run_d  = 1'b0;
              status = (jcan_q || tick_cancel) ? ST_CANCELLED : ST_FINISHED;
            end else begin
              status = ST_WAITING;
            end
          end else if (outst_q >= depth) begin
            status = ST_WAITING;
          end else if (!cfg_i.pacing_off && (time_inc < due_q)) begin
            gap_cnt_d = gcnt_sum[AddrW] ? AddrMax : gcnt_sum[AddrW-1:0];
            status    = ST_WAITING;
          end else begin
            res_len  = len;
            res_sa   = sa;
            res_da   = da;
            offset_d = offset_issue;
            res_last = offset_issue >= total_q;
            outst_d  = outst_q + DepthW'(1);
            if (chunks_q != CountMax) chunks_d = chunks_q + CountW'(1);
            if (!cfg_i.pacing_off && (rate_q != '0)) due_d = due_issue;
            status = ST_ISSUED;
          end
        end
      end
      OP_DONE: begin
        if (outst_q != '0) begin
          outst_d = outst_q - DepthW'(1);
          if (run_q && (outst_q == {{(DepthW-1){1'b0}}, 1'b1})
              && (jcan_q || !has_left)) begin
            run_d  = 1'b0;
            status = jcan_q ? ST_CANCELLED : ST_FINISHED;
          end
        end
      end
      OP_SET_RATE:     rate_d  = item_i.rate_value;
      OP_CANCEL: begin
        cflag_d = 1'b1;
        if (run_q && has_left) jcan_d = 1'b1;
      end
      OP_CLEAR_CANCEL: cflag_d = 1'b0;
      default:         status  = ST_ACK;
    endcase
  end

  // State update only when a beat moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q    <= '0;
      due_q     <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      gap_cnt_q <= '0;
      total_q   <= '0;
      offset_q  <= '0;
      outst_q   <= '0;
      chunks_q  <= '0;
      rate_q    <= '0;
      run_q     <= 1'b0;
      cflag_q   <= 1'b0;
      jcan_q    <= 1'b0;
    end else if (fire_i) begin
      time_q    <= time_d;
      due_q     <= due_d;
      src_q     <= src_d;
      dst_q     <= dst_d;
      gap_cnt_q <= gap_cnt_d;
      total_q   <= total_d;
      offset_q  <= offset_d;
      outst_q   <= outst_d;
      chunks_q  <= chunks_d;
      rate_q    <= rate_d;
      run_q     <= run_d;
      cflag_q   <= cflag_d;
      jcan_q    <= jcan_d;
    end
  end

  // Result reflects state after the step
  always_comb begin
    res_o.status         = status;
    res_o.source_address = res_sa;
    res_o.dest_address   = res_da;
    res_o.chunk_length   = res_len;
    res_o.last_chunk     = res_last;
    res_o.chunks_sent    = chunks_d;
    res_o.bytes_sent     = offset_d;
    res_o.gap_ticks      = gap_cnt_d;
    res_o.deadline_now   = due_d;
    res_o.in_flight      = outst_d;
    res_o.was_cancelled  = jcan_d;
  end

endmodule

// File: rtl/paced_dma_chunk_issuer.sv
// Paced DMA chunk issuer: splits a copy job into chunks and issues one
// descriptor per tick beat, bounded by an in-flight window and a deadline.
//
// Input channel (in_valid_i / in_stall_o) carries one command beat: start,
// tick, chunk done, set rate, cancel, clear cancel. Every command beat gives
// exactly one result beat on the output channel (out_valid_o / out_stall_i).
// The APB-style port sets chunk size, pacing mode and window depth; write it
// only while no command is pending.
// An accepted beat goes through the input register, then the step logic into
// the result register. Throughput: 1 beat per cycle while out_stall_i is low;
// the deadline multiply-add in the step logic sets the clock period.
// When the receiver stalls, the result register holds, the input register
// fills and then in_stall_o rises; no beat is lost or repeated.
// Reset clears time, deadline, job state, counters, pace rate and the cancel
// flag, and loads chunk size 1 MiB, pacing on and window depth 2.
// Depends on pdci_pkg, pdci_cfg and pdci_core.
module paced_dma_chunk_issuer #(
  parameter int unsigned MAX_WINDOW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdci_pkg::PaddrW-1:0]   paddr,
  input  logic [pdci_pkg::PdataW-1:0]   pwdata,
  output logic [pdci_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    opcode_i,
  input  logic [pdci_pkg::BytesW-1:0]   job_bytes_i,
  input  logic [pdci_pkg::AddrW-1:0]    source_base_i,
  input  logic [pdci_pkg::AddrW-1:0]    dest_base_i,
  input  logic [pdci_pkg::AddrW-1:0]    first_due_i,
  input  logic [pdci_pkg::RateW-1:0]    rate_value_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [pdci_pkg::AddrW-1:0]    source_address_o,
  output logic [pdci_pkg::AddrW-1:0]    dest_address_o,
  output logic [pdci_pkg::LenW-1:0]     chunk_length_o,
  output logic                          last_chunk_o,
  output logic [pdci_pkg::CountW-1:0]   chunks_sent_o,
  output logic [pdci_pkg::BytesW-1:0]   bytes_sent_o,
  output logic [pdci_pkg::AddrW-1:0]    gap_ticks_o,
  output logic [pdci_pkg::AddrW-1:0]    deadline_now_o,
  output logic [pdci_pkg::DepthW-1:0]   in_flight_o,
  output logic                          was_cancelled_o
);
  import pdci_pkg::*;

  cfg_t    cfg;
  item_t   item_q, item_d;
  result_t res, res_q;
  logic    in_vld_q, in_vld_d, out_vld_q, out_vld_d;
  logic    out_free, fire, in_take;

  pdci_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: step fires when the result register is free or draining
  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    item_d.opcode      = opcode_i;
    item_d.job_bytes   = job_bytes_i;
    item_d.source_base = source_base_i;
    item_d.dest_base   = dest_base_i;
    item_d.first_due   = first_due_i;
    item_d.rate_value  = rate_value_i;
  end

  assign in_vld_d  = in_take ? 1'b1 : (fire ? 1'b0 : in_vld_q);
  assign out_vld_d = fire ? 1'b1 : (out_stall_i ? out_vld_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Input and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) item_q <= item_d;
    if (fire)    res_q  <= res;
  end

  pdci_core #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o      = out_vld_q;
  assign status_o         = res_q.status;
  assign source_address_o = res_q.source_address;
  assign dest_address_o   = res_q.dest_address;
  assign chunk_length_o   = res_q.chunk_length;
  assign last_chunk_o     = res_q.last_chunk;
  assign chunks_sent_o    = res_q.chunks_sent;
  assign bytes_sent_o     = res_q.bytes_sent;
  assign gap_ticks_o      = res_q.gap_ticks;
  assign deadline_now_o   = res_q.deadline_now;
  assign in_flight_o      = res_q.in_flight;
  assign was_cancelled_o  = res_q.was_cancelled;

endmodule

// File: tb/pdci_result_checker.sv
// pdci_result_checker: watches the command, result and register ports of the
// paced DMA chunk issuer, predicts every result beat and compares it.
// Depends on pdci_pkg.
`timescale 1ns / 1ps

module pdci_result_checker #(
  parameter int unsigned MAX_WINDOW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [pdci_pkg::PaddrW-1:0]   paddr,
  input  logic [pdci_pkg::PdataW-1:0]   pwdata,
  // command channel
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [2:0]                    opcode_i,
  input  logic [pdci_pkg::BytesW-1:0]   job_bytes_i,
  input  logic [pdci_pkg::AddrW-1:0]    source_base_i,
  input  logic [pdci_pkg::AddrW-1:0]    dest_base_i,
  input  logic [pdci_pkg::AddrW-1:0]    first_due_i,
  input  logic [pdci_pkg::RateW-1:0]    rate_value_i,
  // result channel
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [2:0]                    status_i,
  input  logic [pdci_pkg::AddrW-1:0]    source_address_i,
  input  logic [pdci_pkg::AddrW-1:0]    dest_address_i,
  input  logic [pdci_pkg::LenW-1:0]     chunk_length_i,
  input  logic                          last_chunk_i,
  input  logic [pdci_pkg::CountW-1:0]   chunks_sent_i,
  input  logic [pdci_pkg::BytesW-1:0]   bytes_sent_i,
  input  logic [pdci_pkg::AddrW-1:0]    gap_ticks_i,
  input  logic [pdci_pkg::AddrW-1:0]    deadline_now_i,
  input  logic [pdci_pkg::DepthW-1:0]   in_flight_i,
  input  logic                          was_cancelled_i,
  // totals for the testbench top
  output int                            pending_o,
  output int                            mismatches_o,
  output int                            beats_o,
  output int                            chunks_o,
  output int                            ended_o,
  output int                            aborted_o
);
  import pdci_pkg::*;

  // Shadow of the issuer state
  cfg_t              cfg;
  logic [AddrW-1:0]  now_tick;
  logic [AddrW-1:0]  due_tick;
  logic [BytesW-1:0] bytes_total;
  logic [BytesW-1:0] bytes_done;
  logic [AddrW-1:0]  src_base_q;
  logic [AddrW-1:0]  dst_base_q;
  logic [DepthW-1:0] in_flight_q;
  logic [CountW-1:0] chunk_cnt;
  logic [AddrW-1:0]  wait_cnt;
  logic [RateW-1:0]  rate_q;
  logic              job_on;
  logic              cancel_req;
  logic              job_aborted;

  result_t expected_results[$];
  result_t want;
  result_t got;
  item_t   cmd;
  int      mism_cnt;
  int      beat_cnt;
  int      chunk_tally;
  int      end_tally;
  int      abort_tally;

  function automatic logic [AddrW-1:0] add_sat48(logic [AddrW-1:0] a, logic [AddrW-1:0] b);
    logic [AddrW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AddrW] ? '1 : s[AddrW-1:0];
  endfunction

  function automatic bit draining();
    return job_aborted || (bytes_done >= bytes_total);
  endfunction

  // Advance the shadow state by one command beat and return its result beat
  function automatic result_t step_issuer(item_t beat);
    result_t           r;
    int unsigned       depth;
    logic [LenW-1:0]   cs;
    logic [LenW-1:0]   len;
    logic [BytesW-1:0] rem;
    logic [AddrW-1:0]  base;
    logic [63:0]       gap;
    r = '0;
    r.status = ST_ACK;
    case (beat.opcode)
      OP_START: begin
        if (job_on) begin
          r.status = ST_BUSY;
        end else if (beat.job_bytes == '0) begin
          r.status = ST_SIZE_ERROR;
        end else begin
          bytes_total = beat.job_bytes;
          bytes_done  = '0;
          src_base_q  = beat.source_base;
          dst_base_q  = beat.dest_base;
          due_tick    = (beat.first_due != '0) ? beat.first_due : now_tick;
          in_flight_q = '0;
          chunk_cnt   = '0;
          wait_cnt    = '0;
          job_aborted = 1'b0;
          job_on      = 1'b1;
        end
      end
      OP_TICK: begin
        now_tick = add_sat48(now_tick, 48'd1);
        if (job_on) begin
          depth = 32'(cfg.window_depth);
          if (depth == 0) depth = 1;
          if (depth > MAX_WINDOW) depth = MAX_WINDOW;
          // a pending cancel catches the job while bytes remain
          if (cancel_req && bytes_done < bytes_total) job_aborted = 1'b1;
          if (draining()) begin
            if (in_flight_q == '0) begin
              job_on   = 1'b0;
              r.status = job_aborted ? ST_CANCELLED : ST_FINISHED;
            end else begin
              r.status = ST_WAITING;
            end
          end else if (in_flight_q >= depth) begin
            r.status = ST_WAITING;
          end else if (!cfg.pacing_off && now_tick < due_tick) begin
            wait_cnt = add_sat48(wait_cnt, 48'd1);
            r.status = ST_WAITING;
          end else begin
            cs = cfg.chunk_size;
            if (cs == '0) cs = LenW'(1);
            if (cs > ChunkMax) cs = ChunkMax;
            rem = bytes_total - bytes_done;
            len = (rem < BytesW'(cs)) ? rem[LenW-1:0] : cs;
            r.source_address = src_base_q + AddrW'(bytes_done);
            r.dest_address   = dst_base_q + AddrW'(bytes_done);
            r.chunk_length   = len;
            bytes_done       = bytes_done + BytesW'(len);
            r.last_chunk     = (bytes_done >= bytes_total);
            in_flight_q      = in_flight_q + DepthW'(1);
            if (chunk_cnt != '1) chunk_cnt = chunk_cnt + CountW'(1);
            // next deadline: later of now and the old one, plus rounded Q8 gap
            if (!cfg.pacing_off && rate_q != '0) begin
              base     = (now_tick > due_tick) ? now_tick : due_tick;
              gap      = (64'(len) * 64'(rate_q) + 64'd128) >> 8;
              due_tick = add_sat48(base, gap[AddrW-1:0]);
            end
            r.status = ST_ISSUED;
          end
        end
      end
      OP_DONE: begin
        if (in_flight_q != '0) begin
          in_flight_q = in_flight_q - DepthW'(1);
          if (job_on && in_flight_q == '0 && draining()) begin
            job_on   = 1'b0;
            r.status = job_aborted ? ST_CANCELLED : ST_FINISHED;
          end
        end
      end
      OP_SET_RATE: rate_q = beat.rate_value;
      OP_CANCEL: begin
        cancel_req = 1'b1;
        if (job_on && bytes_done < bytes_total) job_aborted = 1'b1;
      end
      OP_CLEAR_CANCEL: cancel_req = 1'b0;
      default: ;
    endcase
    r.chunks_sent   = chunk_cnt;
    r.bytes_sent    = bytes_done;
    r.gap_ticks     = wait_cnt;
    r.deadline_now  = due_tick;
    r.in_flight     = in_flight_q;
    r.was_cancelled = job_aborted;
    return r;
  endfunction

  task automatic show_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) $display("  %s: expected %h, got %h", name, e, a);
  endtask

  // Sample all three ports at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.chunk_size   = ChunkSizeRst;
      cfg.pacing_off   = PacingOffRst;
      cfg.window_depth = WindowDepthRst;
      now_tick    = '0;
      due_tick    = '0;
      bytes_total = '0;
      bytes_done  = '0;
      src_base_q  = '0;
      dst_base_q  = '0;
      in_flight_q = '0;
      chunk_cnt   = '0;
      wait_cnt    = '0;
      rate_q      = '0;
      job_on      = 1'b0;
      cancel_req  = 1'b0;
      job_aborted = 1'b0;
      expected_results.delete();
      mism_cnt    = 0;
      beat_cnt    = 0;
      chunk_tally = 0;
      end_tally   = 0;
      abort_tally = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_CHUNK_SIZE:   cfg.chunk_size   = pwdata[LenW-1:0];
          REG_PACING_OFF:   cfg.pacing_off   = pwdata[0];
          REG_WINDOW_DEPTH: cfg.window_depth = pwdata[DepthW-1:0];
          default: ;
        endcase
      end

      // result beat against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        beat_cnt++;
        if (expected_results.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("Result beat %0d arrived with no command waiting for it", beat_cnt);
        end else begin
          want = expected_results.pop_front();
          got.status         = status_e'(status_i);
          got.source_address = source_address_i;
          got.dest_address   = dest_address_i;
          got.chunk_length   = chunk_length_i;
          got.last_chunk     = last_chunk_i;
          got.chunks_sent    = chunks_sent_i;
          got.bytes_sent     = bytes_sent_i;
          got.gap_ticks      = gap_ticks_i;
          got.deadline_now   = deadline_now_i;
          got.in_flight      = in_flight_i;
          got.was_cancelled  = was_cancelled_i;
          if (got !== want) begin
            mism_cnt++;
            if (mism_cnt <= 10) begin
              $display("Result beat %0d differs at %0t:", beat_cnt, $realtime);
              show_field("status", 64'(want.status), 64'(got.status));
              show_field("source_address", 64'(want.source_address),
                         64'(got.source_address));
              show_field("dest_address", 64'(want.dest_address), 64'(got.dest_address));
              show_field("chunk_length", 64'(want.chunk_length), 64'(got.chunk_length));
              show_field("last_chunk", 64'(want.last_chunk), 64'(got.last_chunk));
              show_field("chunks_sent", 64'(want.chunks_sent), 64'(got.chunks_sent));
              show_field("bytes_sent", 64'(want.bytes_sent), 64'(got.bytes_sent));
              show_field("gap_ticks", 64'(want.gap_ticks), 64'(got.gap_ticks));
              show_field("deadline_now", 64'(want.deadline_now), 64'(got.deadline_now));
              show_field("in_flight", 64'(want.in_flight), 64'(got.in_flight));
              show_field("was_cancelled", 64'(want.was_cancelled),
                         64'(got.was_cancelled));
            end
          end
        end
      end

      // command beat: predict its result
      if (in_valid_i && !in_stall_i) begin
        cmd.opcode      = opcode_i;
        cmd.job_bytes   = job_bytes_i;
        cmd.source_base = source_base_i;
        cmd.dest_base   = dest_base_i;
        cmd.first_due   = first_due_i;
        cmd.rate_value  = rate_value_i;
        want = step_issuer(cmd);
        expected_results.push_back(want);
        if (want.status == ST_ISSUED) chunk_tally++;
        if (want.status == ST_FINISHED || want.status == ST_CANCELLED) end_tally++;
        if (want.status == ST_CANCELLED) abort_tally++;
      end
    end
    pending_o    <= expected_results.size();
    mismatches_o <= mism_cnt;
    beats_o      <= beat_cnt;
    chunks_o     <= chunk_tally;
    ended_o      <= end_tally;
    aborted_o    <= abort_tally;
  end

endmodule

// File: tb/paced_dma_chunk_issuer_test.sv
// paced_dma_chunk_issuer_test: drives commands, register writes and result
// stalls into the chunk issuer and gives the verdict.
// Depends on pdci_pkg, paced_dma_chunk_issuer and pdci_result_checker.
`timescale 1ns / 1ps

module paced_dma_chunk_issuer_test;
  import pdci_pkg::*;

  localparam int unsigned ItemTarget = 1750;
  localparam int unsigned Phases     = 8;
  localparam int unsigned CycleLimit = 400000;
  // opcodes the block leaves unused
  localparam logic [2:0]  OpSpare6   = 3'd6;
  localparam logic [2:0]  OpSpare7   = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [PaddrW-1:0] paddr   = '0;
  logic [PdataW-1:0] pwdata  = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [2:0]        opcode      = '0;
  logic [BytesW-1:0] job_bytes   = '0;
  logic [AddrW-1:0]  source_base = '0;
  logic [AddrW-1:0]  dest_base   = '0;
  logic [AddrW-1:0]  first_due   = '0;
  logic [RateW-1:0]  rate_value  = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        status;
  logic [AddrW-1:0]  source_address;
  logic [AddrW-1:0]  dest_address;
  logic [LenW-1:0]   chunk_length;
  logic              last_chunk;
  logic [CountW-1:0] chunks_sent;
  logic [BytesW-1:0] bytes_sent;
  logic [AddrW-1:0]  gap_ticks;
  logic [AddrW-1:0]  deadline_now;
  logic [DepthW-1:0] in_flight;
  logic              was_cancelled;

  int pending;
  int mismatches;
  int beats_seen;
  int chunks_seen;
  int jobs_ended;
  int jobs_aborted;

  int unsigned items_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned cs_eff     = 1048576;
  int unsigned depth_eff  = 2;
  int          burst_left = 8;
  bit          gaps_on    = 1'b1;
  int unsigned cycle_cnt  = 0;
  int          stall_mode = 0;
  int          stall_left = 0;

  always #2 clk = ~clk;

  paced_dma_chunk_issuer dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .job_bytes_i      (job_bytes),
    .source_base_i    (source_base),
    .dest_base_i      (dest_base),
    .first_due_i      (first_due),
    .rate_value_i     (rate_value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .source_address_o (source_address),
    .dest_address_o   (dest_address),
    .chunk_length_o   (chunk_length),
    .last_chunk_o     (last_chunk),
    .chunks_sent_o    (chunks_sent),
    .bytes_sent_o     (bytes_sent),
    .gap_ticks_o      (gap_ticks),
    .deadline_now_o   (deadline_now),
    .in_flight_o      (in_flight),
    .was_cancelled_o  (was_cancelled)
  );

  pdci_result_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .opcode_i         (opcode),
    .job_bytes_i      (job_bytes),
    .source_base_i    (source_base),
    .dest_base_i      (dest_base),
    .first_due_i      (first_due),
    .rate_value_i     (rate_value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .source_address_i (source_address),
    .dest_address_i   (dest_address),
    .chunk_length_i   (chunk_length),
    .last_chunk_i     (last_chunk),
    .chunks_sent_i    (chunks_sent),
    .bytes_sent_i     (bytes_sent),
    .gap_ticks_i      (gap_ticks),
    .deadline_now_i   (deadline_now),
    .in_flight_i      (in_flight),
    .was_cancelled_i  (was_cancelled),
    .pending_o        (pending),
    .mismatches_o     (mismatches),
    .beats_o          (beats_seen),
    .chunks_o         (chunks_seen),
    .ended_o          (jobs_ended),
    .aborted_o        (jobs_aborted)
  );

  // Result stalls: a random mode is held for a random run, then redrawn
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 256);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_left % 5) < 2);
    endcase
  end

  function automatic logic [AddrW-1:0] rand_addr();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[AddrW-1:0];
  endfunction

  function automatic logic [BytesW-1:0] rand_bytes();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[BytesW-1:0];
  endfunction

  // One command beat; holds until accepted, then maybe idles between bursts
  task automatic send_beat(logic [2:0] op, logic [BytesW-1:0] nb, logic [AddrW-1:0] src,
                           logic [AddrW-1:0] dst, logic [AddrW-1:0] due,
                           logic [RateW-1:0] rate);
    in_valid    <= 1'b1;
    opcode      <= op;
    job_bytes   <= nb;
    source_base <= src;
    dest_base   <= dst;
    first_due   <= due;
    rate_value  <= rate;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (op == OP_TICK) ticks_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Command with random content in the fields it does not use
  task automatic send_cmd(logic [2:0] op);
    send_beat(op, rand_bytes(), rand_addr(), rand_addr(), rand_addr(), RateW'($urandom));
  endtask

  task automatic send_rate(logic [RateW-1:0] rate);
    send_beat(OP_SET_RATE, rand_bytes(), rand_addr(), rand_addr(), rand_addr(), rate);
  endtask

  // Hold off until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [PdataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Register setting per phase; the first few hit the extremes
  task automatic apply_setting(int unsigned phase);
    logic [LenW-1:0]   chunk;
    logic              pace_off;
    logic [DepthW-1:0] depth;
    case (phase)
      1: begin chunk = '0;       pace_off = 1'b0; depth = 4'd0;  end
      2: begin chunk = 25'd1;    pace_off = 1'b0; depth = 4'd8;  end
      3: begin chunk = '1;       pace_off = 1'b1; depth = 4'd15; end
      4: begin chunk = ChunkMax; pace_off = 1'b1; depth = 4'd1;  end
      default: begin
        chunk    = LenW'($urandom_range(2, 300));
        pace_off = 1'($urandom_range(0, 1));
        depth    = DepthW'($urandom_range(0, 15));
      end
    endcase
    write_reg(REG_CHUNK_SIZE, PdataW'(chunk));
    write_reg(REG_PACING_OFF, PdataW'(pace_off));
    write_reg(REG_WINDOW_DEPTH, PdataW'(depth));
    cs_eff    = (chunk == '0) ? 1 : ((chunk > ChunkMax) ? ChunkMax : chunk);
    depth_eff = (depth == '0) ? 1 : ((depth > 8) ? 8 : depth);
  endtask

  // Short directed pass under the reset register values
  task automatic directed_checks();
    // idle block: tick, stray done, empty job, spare opcodes
    send_cmd(OP_TICK);
    send_cmd(OP_DONE);
    send_beat(OP_START, '0, rand_addr(), rand_addr(), rand_addr(), RateW'($urandom));
    send_cmd(OpSpare6);
    send_cmd(OpSpare7);
    send_rate('1);
    send_rate('0);
    // cancel raised while idle kills the next job on its first tick
    send_cmd(OP_CANCEL);
    send_beat(OP_START, 40'd3145733, 48'hFFFF_FFFF_FFF0, '0, '0, RateW'($urandom));
    send_cmd(OP_TICK);
    send_cmd(OP_CLEAR_CANCEL);
    // two full chunks and one byte, both addresses wrap; busy on restart
    send_beat(OP_START, 40'd2097153, 48'hFFFF_FFFF_0000, '1, '0, RateW'($urandom));
    send_beat(OP_START, 40'd5, rand_addr(), rand_addr(), '0, RateW'($urandom));
    send_cmd(OP_TICK);
    send_cmd(OP_TICK);
    send_cmd(OP_TICK);
    send_cmd(OP_DONE);
    send_cmd(OP_TICK);
    send_cmd(OP_TICK);
    send_cmd(OP_DONE);
    send_cmd(OP_DONE);
    send_cmd(OP_DONE);
    // largest job with the deadline at the end of time, then cancelled
    send_beat(OP_START, '1, rand_addr(), rand_addr(), '1, RateW'($urandom));
    send_cmd(OP_TICK);
    send_cmd(OP_CANCEL);
    send_cmd(OP_TICK);
    send_cmd(OP_CLEAR_CANCEL);
  endtask

  // One job: optional rate and early cancel, start, a mix of ticks and
  // completions with some noise, then a cancel that drains whatever is left
  task automatic run_job();
    int unsigned       chunk_goal;
    int unsigned       steps;
    int unsigned       pick;
    int unsigned       rmax;
    logic [BytesW-1:0] nb;
    logic [AddrW-1:0]  src;
    logic [AddrW-1:0]  dst;
    logic [AddrW-1:0]  due;
    chunk_goal = $urandom_range(1, 10);
    nb = BytesW'(cs_eff * chunk_goal - $urandom_range(0, cs_eff - 1));
    pick = $urandom_range(0, 63);
    if (pick < 4) nb = rand_bytes();
    else if (pick < 6) nb = '1;
    else if (pick < 9) nb = '0;
    src = rand_addr();
    dst = rand_addr();
    if ($urandom_range(0, 7) == 0) src = '1 - AddrW'($urandom_range(0, 4 * cs_eff));
    if ($urandom_range(0, 7) == 0) dst = '1 - AddrW'($urandom_range(0, 4 * cs_eff));
    due = $urandom_range(0, 1) ? '0 : AddrW'(ticks_sent + $urandom_range(0, 24));
    if ($urandom_range(0, 31) == 0) due = rand_addr();
    rmax = 1536 / cs_eff;
    if ($urandom_range(0, 2) != 0) send_rate(RateW'($urandom_range(0, rmax)));
    if ($urandom_range(0, 19) == 0) send_cmd(OP_CANCEL);
    send_beat(OP_START, nb, src, dst, due, RateW'($urandom));

    steps = chunk_goal * 4 + $urandom_range(4, 20);
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) send_cmd(OP_TICK);
      else if (pick < 85) send_cmd(OP_DONE);
      else if (pick < 88) send_cmd(OP_CANCEL);
      else if (pick < 90) send_rate(RateW'($urandom_range(0, rmax)));
      else if (pick < 92) send_beat(OP_START, nb, src, dst, due, RateW'($urandom));
      else if (pick < 94) send_cmd(OP_CLEAR_CANCEL);
      else send_cmd(3'($urandom_range(0, 7)));
    end
    if ($urandom_range(0, 29) == 0) drain();

    send_cmd(OP_CANCEL);
    repeat (depth_eff) send_cmd(OP_DONE);
    send_cmd(OP_TICK);
    send_cmd(OP_CLEAR_CANCEL);
  endtask

  // Watchdog
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned phase_base;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();
    for (int unsigned phase = 0; phase < Phases; phase++) begin
      if (phase > 0) begin
        drain();
        apply_setting(phase);
      end
      gaps_on    = (phase != 3);
      phase_base = items_sent;
      while (items_sent - phase_base < ItemTarget / Phases) run_job();
    end
    drain();
    $display("Sent %0d commands (%0d ticks) over %0d register settings with throttling.",
             items_sent, ticks_sent, Phases);
    $display("Checked %0d result beats: %0d chunks issued, %0d jobs ended, %0d cancelled.",
             beats_seen, chunks_seen, jobs_ended, jobs_aborted);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
